// ===== src/gf256_poly_remainder_assert.svh =====
// ----------------------------------------------------------------------------
// gf256_poly_remainder_assert.svh
// Assertion macros shared by the GF(256) remainder unit.
// ----------------------------------------------------------------------------
`ifndef GF256_POLY_REMAINDER_ASSERT_SVH
`define GF256_POLY_REMAINDER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define GFPR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define GFPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/gfpr_pkg.sv =====
// ----------------------------------------------------------------------------
// gfpr_pkg
// Shared constants, types and the GF(256) multiplier for the remainder unit.
// ----------------------------------------------------------------------------
package gfpr_pkg;

  localparam int MAX_DEGREE = 32;
  // Holds 0..MAX_DEGREE.
  localparam int DEG_W = $clog2(MAX_DEGREE + 1);
  // Compare width for degree clamping and coefficient index match (MAX_DEGREE <= 64).
  localparam int CMP_W = 7;

  // Configuration register indexes.
  localparam logic REG_FIELD_POLY = 1'b0;
  localparam logic REG_DIV_DEGREE = 1'b1;

  localparam logic OP_LOAD_COEF = 1'b0;
  localparam logic OP_DIVIDEND  = 1'b1;

  localparam logic [8:0] FIELD_POLY_RESET = 9'd285;
  localparam logic [5:0] DIV_DEGREE_RESET = 6'd16;

  // Broadcast controls shared by every cell.
  typedef struct packed {
    logic       shift;       // dividend byte transfer
    logic       clear;       // final dividend byte: clear window after the step
    logic       snap_load;   // capture the finished window for output
    logic       snap_shift;  // output transfer: advance the output chain
    logic [7:0] top;         // outgoing high-degree coefficient
    logic [7:0] red;         // low 8 bits of the field polynomial
    logic [7:0] value;       // incoming dividend byte or coefficient
  } cell_ctrl_t;

  // Per-cell position decode.
  typedef struct packed {
    logic active;   // cell index below the live degree
    logic tail;     // cell index equals live degree minus one
    logic coef_we;  // coefficient write aimed at this cell
  } cell_sel_t;

  // GF(256) product, field reduced by red (x^8 implied).
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] red);
    logic [7:0] x;
    logic [7:0] acc;
    logic       carry;
    x   = a;
    acc = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc = acc ^ x;
      carry = x[7];
      x     = {x[6:0], 1'b0};
      if (carry) x = x ^ red;
    end
    return acc;
  endfunction

endpackage

// ===== src/gfpr_cell.sv =====
// ----------------------------------------------------------------------------
// gfpr_cell
// One stage of the remainder window: coefficient, window byte, output byte.
// ----------------------------------------------------------------------------
module gfpr_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  gfpr_pkg::cell_ctrl_t ctrl,
  input  gfpr_pkg::cell_sel_t  sel,
  input  logic [7:0]           win_right,
  input  logic [7:0]           snap_right,
  output logic [7:0]           win,
  output logic [7:0]           snap
);

  logic [7:0] coef;
  logic [7:0] shifted;
  logic [7:0] win_step;

  always_comb begin
    shifted  = sel.tail ? ctrl.value : win_right;
    win_step = sel.active ? (shifted ^ gfpr_pkg::gf_mul(coef, ctrl.top, ctrl.red)) : win;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coef <= 8'h00;
      win  <= 8'h00;
    end else begin
      if (sel.coef_we) coef <= ctrl.value;
      if (ctrl.shift) begin
        win <= ctrl.clear ? 8'h00 : win_step;
      end
    end
  end

  // Output chain: payload only, qualified by the count in the top level.
  always_ff @(posedge clk) begin
    if (ctrl.snap_load) begin
      snap <= win_step;
    end else if (ctrl.snap_shift) begin
      snap <= snap_right;
    end
  end

endmodule

// ===== src/gf256_poly_remainder.sv =====
// ----------------------------------------------------------------------------
// gf256_poly_remainder
// GF(256) remainder of a streamed dividend modulo a monic divisor.
// ----------------------------------------------------------------------------
// Accepts one item per clock: a divisor coefficient load (op 0) or a dividend
// byte (op 1), highest degree first. The window is a row of MAX_DEGREE cells;
// on each dividend transfer the top byte is broadcast to every cell, each
// cell multiplies it by its own coefficient in GF(256) and XORs it into the
// byte handed over from its right neighbor, and
// the broadcast-plus-multiply through the row sets the clock. On the final
// byte the finished window is copied into a second chain in the same cells,
// and the window is cleared, so the next message can start in the next cycle.
// The copy drains at one remainder byte per output transfer, d transfers per
// message (d = divisor_degree clamped to 1..MAX_DEGREE), last_byte on the
// final one. A final dividend byte is stalled only while the previous
// remainder is still draining (beyond its last output transfer); messages of
// at least d bytes run at full rate with an unstalled output. Configuration
// writes are applied the cycle after cfg_we and must be done while idle.
// ----------------------------------------------------------------------------
module gf256_poly_remainder (
  input  logic       clk,
  input  logic       rst,
  // configuration
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [8:0] cfg_data,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       op,
  input  logic [5:0] coef_index,
  input  logic [7:0] value,
  input  logic       last,
  // output channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] remainder_byte,
  output logic       last_byte
);

`include "gf256_poly_remainder_assert.svh"

  localparam int MAXD = gfpr_pkg::MAX_DEGREE;
  localparam int DW   = gfpr_pkg::DEG_W;
  localparam int CW   = gfpr_pkg::CMP_W;

  logic [8:0]    field_polynomial;
  logic [5:0]    divisor_degree;
  logic [DW-1:0] count;
  logic [DW-1:0] count_next;

  logic [CW-1:0] deg_ext;
  logic [DW-1:0] deg;
  logic          in_xfer;
  logic          out_xfer;
  logic          div_xfer;
  logic          fin;
  logic          busy;

  gfpr_pkg::cell_ctrl_t ctrl;

  // Index MAXD is a tied-off neighbor past the far end of the row.
  logic [7:0] win_q  [MAXD+1];
  logic [7:0] snap_q [MAXD+1];

  // Clamp the degree to 1..MAX_DEGREE.
  always_comb begin
    deg_ext = CW'(divisor_degree);
    if (deg_ext == '0) begin
      deg_ext = CW'(1);
    end else if (deg_ext > CW'(MAXD)) begin
      deg_ext = CW'(MAXD);
    end
    deg = deg_ext[DW-1:0];
  end

  // Output chain still holds bytes after this cycle.
  assign busy      = (count != '0) && !((count == DW'(1)) && out_xfer);
  assign in_stall  = in_valid && (op == gfpr_pkg::OP_DIVIDEND) && last && busy;
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = (count != '0);
  assign out_xfer  = out_valid && !out_stall;
  assign div_xfer  = in_xfer && (op == gfpr_pkg::OP_DIVIDEND);
  assign fin       = div_xfer && last;

  assign remainder_byte = snap_q[0];
  assign last_byte      = (count == DW'(1));

  always_comb begin
    ctrl.shift      = div_xfer;
    ctrl.clear      = fin;
    ctrl.snap_load  = fin;
    ctrl.snap_shift = out_xfer;
    ctrl.top        = win_q[0];
    ctrl.red        = field_polynomial[7:0];
    ctrl.value      = value;
  end

  always_comb begin
    count_next = count;
    if (fin) begin
      count_next = deg;
    end else if (out_xfer) begin
      count_next = count - DW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      field_polynomial <= gfpr_pkg::FIELD_POLY_RESET;
      divisor_degree   <= gfpr_pkg::DIV_DEGREE_RESET;
      count            <= '0;
    end else begin
      count <= count_next;
      if (cfg_we) begin
        case (cfg_index)
          gfpr_pkg::REG_FIELD_POLY: field_polynomial <= cfg_data;
          gfpr_pkg::REG_DIV_DEGREE: divisor_degree   <= cfg_data[5:0];
          default: ;
        endcase
      end
    end
  end

  assign win_q[MAXD]  = 8'h00;
  assign snap_q[MAXD] = 8'h00;

  // Row of window cells; cell k holds the coefficient of x^(d-1-k).
  for (genvar k = 0; k < MAXD; k++) begin : g_cell
    localparam logic [CW-1:0] POS = CW'(k);
    gfpr_pkg::cell_sel_t sel;

    always_comb begin
      sel.active  = (POS < CW'(deg));
      sel.tail    = (POS == (CW'(deg) - CW'(1)));
      sel.coef_we = in_xfer && (op == gfpr_pkg::OP_LOAD_COEF) &&
                    (CW'(coef_index) == (POS + CW'(1)));
    end

    gfpr_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .sel        (sel),
      .win_right  (win_q[k+1]),
      .snap_right (snap_q[k+1]),
      .win        (win_q[k]),
      .snap       (snap_q[k])
    );
  end

  // A new remainder never lands on one that is still draining.
  `GFPR_ASSERT_NOW(a_no_overwrite, fin, (count == '0) || ((count == DW'(1)) && out_xfer), "remainder overwritten before drained")
  // The final byte of a remainder ends the burst unless a new one starts.
  `GFPR_ASSERT_NEXT(a_burst_end, out_xfer && last_byte && !fin, !out_valid, "output continues past last_byte")
  // A coefficient load leaves the window alone.
  `GFPR_ASSERT_NEXT(a_load_keeps_win, in_xfer && (op == gfpr_pkg::OP_LOAD_COEF), $stable(win_q[0]), "coefficient load disturbed the window")
  // A final dividend byte leaves a cleared window behind.
  `GFPR_ASSERT_NEXT(a_clear_after_last, fin, win_q[0] == 8'h00, "window not cleared after final byte")

endmodule

// ===== test/gf256_poly_remainder_test.sv =====
// ----------------------------------------------------------------------------
// gf256_poly_remainder_test
// Self-checking bench for the GF(256) polynomial remainder unit.
// ----------------------------------------------------------------------------
// Loads divisor coefficients and streams dividend bytes into the block, and
// keeps a bit-true copy of the divisor and the remainder window. Every
// remainder byte that leaves the block is compared against the oldest
// predicted byte. A directed part covers the byte extremes, ignored
// coefficient slots, short dividends and a degree change in mid-message.
// Random phases then sweep field polynomials and divisor degrees, with random
// gaps and stalls on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module gf256_poly_remainder_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 16;    // quiet time before and after a register write
  localparam int HOLD_CYCLES   = 300;   // long output hold-off
  localparam int STALL_LIMIT   = 2000;  // cycles without any transfer before giving up
  localparam int PHASE_BYTES   = 24;    // dividend budget of one random phase

  typedef struct packed {
    logic [7:0] rbyte;
    logic       final_byte;
  } rem_byte_t;

  // Bit-true copy of the divisor and the remainder window, plus the queue of
  // remainder bytes still owed by the block.
  class remainder_calc;
    logic [8:0] field_poly;
    logic [5:0] degree;
    logic [7:0] divisor[gfpr_pkg::MAX_DEGREE];
    logic [7:0] window[gfpr_pkg::MAX_DEGREE];
    rem_byte_t  due_bytes[$];
    int         mismatches;

    function new();
      field_poly = gfpr_pkg::FIELD_POLY_RESET;
      degree     = gfpr_pkg::DIV_DEGREE_RESET;
      foreach (divisor[k]) divisor[k] = 8'h00;
      foreach (window[k]) window[k] = 8'h00;
      mismatches = 0;
    endfunction

    function void set_reg(logic ri, logic [8:0] data);
      if (ri == gfpr_pkg::REG_FIELD_POLY) field_poly = data;
      else degree = data[5:0];
    endfunction

    // Degree 0 runs as 1; anything past MAX_DEGREE runs as MAX_DEGREE.
    function int span();
      if (degree == 0) return 1;
      if (degree > gfpr_pkg::MAX_DEGREE) return gfpr_pkg::MAX_DEGREE;
      return degree;
    endfunction

    // Horner form, MSB of a first; x^8 folds back through the low byte only.
    function logic [7:0] gf_times(logic [7:0] a, logic [7:0] b);
      logic [7:0] p;
      p = 8'h00;
      for (int i = 7; i >= 0; i--) begin
        p = {p[6:0], 1'b0} ^ (p[7] ? field_poly[7:0] : 8'h00);
        if (a[i]) p = p ^ b;
      end
      return p;
    endfunction

    function void take_item(logic o, logic [5:0] ix, logic [7:0] v, logic l);
      int         d;
      logic [7:0] top;
      rem_byte_t  res;
      if (o == gfpr_pkg::OP_LOAD_COEF) begin
        if (ix >= 1 && ix <= gfpr_pkg::MAX_DEGREE) divisor[ix - 1] = v;
        return;
      end
      d   = span();
      top = window[0];
      // Only the live part of the window shifts; entries above it stay put.
      for (int k = 0; k < d - 1; k++) window[k] = window[k + 1];
      window[d - 1] = v;
      if (top != 8'h00)
        for (int k = 0; k < d; k++) window[k] = window[k] ^ gf_times(divisor[k], top);
      if (!l) return;
      for (int k = 0; k < d; k++) begin
        res.rbyte      = window[k];
        res.final_byte = (k == d - 1);
        due_bytes.push_back(res);
      end
      foreach (window[k]) window[k] = 8'h00;
    endfunction

    function void check_byte(logic [7:0] rb, logic lb);
      rem_byte_t want;
      if (due_bytes.size() == 0) begin
        $error("remainder byte %02h arrived with no result pending", rb);
        mismatches++;
        return;
      end
      want = due_bytes.pop_front();
      if (rb !== want.rbyte) begin
        $error("remainder_byte: expected %02h, got %02h", want.rbyte, rb);
        mismatches++;
      end
      if (lb !== want.final_byte) begin
        $error("last_byte: expected %0b, got %0b", want.final_byte, lb);
        mismatches++;
      end
    endfunction
  endclass

  logic       clk        = 1'b0;
  logic       rst        = 1'b1;
  logic       cfg_we     = 1'b0;
  logic       cfg_index  = gfpr_pkg::REG_FIELD_POLY;
  logic [8:0] cfg_data   = '0;
  logic       in_valid   = 1'b0;
  logic       in_stall;
  logic       op         = gfpr_pkg::OP_LOAD_COEF;
  logic [5:0] coef_index = '0;
  logic [7:0] value      = '0;
  logic       last       = 1'b0;
  logic       out_valid;
  logic       out_stall  = 1'b0;
  logic [7:0] remainder_byte;
  logic       last_byte;

  remainder_calc calc;
  int stuck_cycles = 0;
  bit hold_req     = 1'b0;  // ask the receiver for one long hold-off
  bit tx_steady    = 1'b0;  // sender offers items back to back

  gf256_poly_remainder DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .op            (op),
    .coef_index    (coef_index),
    .value         (value),
    .last          (last),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .remainder_byte(remainder_byte),
    .last_byte     (last_byte)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sample every transfer at the rising edge: register writes and input
  // transfers feed the predictor, output transfers are checked against it.
  // Count cycles with no transfer of any kind for the watchdog.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) calc.set_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) calc.take_item(op, coef_index, value, last);
      if (out_valid && !out_stall) calc.check_byte(remainder_byte, last_byte);
      if (cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) stuck_cycles <= 0;
      else stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (stuck_cycles >= STALL_LIMIT);
    $error("no transfer for %0d cycles", STALL_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  // Output side pacing. Run in segments: free flow, scattered stalls, or one
  // solid stall. A hold request overrides everything with one long hold-off.
  initial begin : rx_pace
    int mode;
    int seg_left;
    int hold_left;
    mode      = 0;
    seg_left  = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        if (seg_left == 0) begin
          mode     = $urandom_range(0, 9);
          seg_left = (mode == 9) ? $urandom_range(15, 60) : $urandom_range(5, 50);
        end
        seg_left--;
        if (mode < 3) out_stall <= 1'b0;
        else if (mode < 9) out_stall <= ($urandom_range(0, 3) == 0);
        else out_stall <= 1'b1;
      end
    end
  end

  // Offer one item and hold it until the transfer, then idle for a random
  // gap: mostly none or short, now and then long. Scramble the payload while
  // valid is low.
  task automatic send_item(input logic o, input logic [5:0] ix, input logic [7:0] v,
                           input logic l);
    int gap;
    int pick;
    @(negedge clk);
    op         <= o;
    coef_index <= ix;
    value      <= v;
    last       <= l;
    in_valid   <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pick = $urandom_range(0, 99);
    if (tx_steady || pick < 55) gap = 0;
    else if (pick < 88) gap = $urandom_range(1, 3);
    else if (pick < 96) gap = $urandom_range(4, 12);
    else gap = $urandom_range(20, 60);
    if (gap > 0) begin
      @(negedge clk);
      in_valid   <= 1'b0;
      op         <= 1'($urandom);
      coef_index <= 6'($urandom);
      value      <= 8'($urandom);
      last       <= 1'($urandom);
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Stream a dividend of random bytes; the final byte carries last.
  task automatic send_message(input int len);
    for (int i = 0; i < len; i++)
      send_item(gfpr_pkg::OP_DIVIDEND, 6'($urandom), 8'($urandom), i == len - 1);
  endtask

  // Drop valid and any write enable, wait until every owed remainder byte
  // has come out, then give the block time to finish internal work.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    cfg_we   <= 1'b0;
    while (calc.due_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write enable is left high; a later write keeps it high and wait_idle lowers it.
  task automatic write_reg(input logic ri, input logic [8:0] d);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= ri;
    cfg_data  <= d;
    @(posedge clk);
  endtask

  task automatic configure(input logic [8:0] poly, input logic [5:0] deg);
    wait_idle();
    write_reg(gfpr_pkg::REG_FIELD_POLY, poly);
    write_reg(gfpr_pkg::REG_DIV_DEGREE, {3'b000, deg});
    wait_idle();
  endtask

  // One random phase: fresh registers, a full divisor, then mostly
  // well-formed dividends (some shorter than the degree) with stray items
  // mixed in, including out-of-range coefficient slots.
  task automatic run_phase(input logic [8:0] poly, input logic [5:0] deg);
    int d;
    int sent;
    int pick;
    int len;
    configure(poly, deg);
    d = calc.span();
    tx_steady = ($urandom_range(0, 3) == 0);
    for (int k = 1; k <= d; k++)
      send_item(gfpr_pkg::OP_LOAD_COEF, 6'(k), 8'($urandom), 1'($urandom));
    sent = 0;
    while (sent < PHASE_BYTES) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        send_item(1'($urandom), 6'($urandom), 8'($urandom), 1'($urandom));
        sent++;
      end else begin
        len = (pick < 8) ? $urandom_range(d, d + 5) : $urandom_range(1, d);
        send_message(len);
        sent += len;
      end
    end
    tx_steady = 1'b0;
  endtask

  initial begin : stimulus
    calc = new();
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // Directed part at degree 4 with the default field.
    configure(gfpr_pkg::FIELD_POLY_RESET, 6'd4);
    send_item(gfpr_pkg::OP_LOAD_COEF, 6'd1, 8'hFF, 1'b1);   // last is ignored on loads
    send_item(gfpr_pkg::OP_LOAD_COEF, 6'd2, 8'h00, 1'b0);
    send_item(gfpr_pkg::OP_LOAD_COEF, 6'd3, 8'h80, 1'b0);
    send_item(gfpr_pkg::OP_LOAD_COEF, 6'd4, 8'h1D, 1'b0);
    send_item(gfpr_pkg::OP_LOAD_COEF, 6'd32, 8'h5A, 1'b0);  // top slot, unused at this degree
    // Out-of-range slots: drop silently.
    send_item(gfpr_pkg::OP_LOAD_COEF, 6'd0, 8'hA5, 1'b1);
    send_item(gfpr_pkg::OP_LOAD_COEF, 6'd33, 8'hA5, 1'b0);
    send_item(gfpr_pkg::OP_LOAD_COEF, 6'd63, 8'hA5, 1'b1);
    // Full dividend with extreme bytes.
    send_item(gfpr_pkg::OP_DIVIDEND, 6'd0, 8'hFF, 1'b0);
    send_item(gfpr_pkg::OP_DIVIDEND, 6'd63, 8'h00, 1'b0);
    send_item(gfpr_pkg::OP_DIVIDEND, 6'd0, 8'h80, 1'b0);
    send_item(gfpr_pkg::OP_DIVIDEND, 6'd0, 8'h01, 1'b0);
    send_item(gfpr_pkg::OP_DIVIDEND, 6'd0, 8'h55, 1'b1);
    // Short dividends come back zero-padded.
    send_item(gfpr_pkg::OP_DIVIDEND, 6'd0, 8'hAB, 1'b0);
    send_item(gfpr_pkg::OP_DIVIDEND, 6'd0, 8'hCD, 1'b1);
    send_item(gfpr_pkg::OP_DIVIDEND, 6'd0, 8'h7F, 1'b1);
    // Degree drops from 4 to 2 in mid-message: the upper entries stay put.
    send_item(gfpr_pkg::OP_DIVIDEND, 6'd0, 8'h12, 1'b0);
    send_item(gfpr_pkg::OP_DIVIDEND, 6'd0, 8'h34, 1'b0);
    send_item(gfpr_pkg::OP_DIVIDEND, 6'd0, 8'h56, 1'b0);
    wait_idle();
    write_reg(gfpr_pkg::REG_DIV_DEGREE, 9'd2);
    wait_idle();
    send_item(gfpr_pkg::OP_DIVIDEND, 6'd0, 8'h9A, 1'b0);
    send_item(gfpr_pkg::OP_DIVIDEND, 6'd0, 8'hBC, 1'b1);

    // Register extremes, including degrees outside the valid span and a
    // field polynomial with bit 8 clear.
    run_phase(9'd256, 6'd1);
    run_phase(9'd511, 6'd32);
    run_phase(9'd285, 6'd0);
    run_phase(9'd283, 6'd63);
    run_phase(9'd0, 6'd3);

    // Back the block up: hold the output off while dividends keep coming, so
    // a finished remainder waits and the next final byte gets stalled.
    configure(9'd301, 6'd4);
    for (int k = 1; k <= 4; k++)
      send_item(gfpr_pkg::OP_LOAD_COEF, 6'(k), 8'($urandom), 1'b0);
    hold_req  = 1'b1;
    tx_steady = 1'b1;
    repeat (6) send_message(5);
    tx_steady = 1'b0;

    for (int i = 0; i < 6; i++)
      run_phase(9'($urandom_range(0, 511)),
                ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63))
                                            : 6'($urandom_range(1, 8)));

    wait_idle();
    if (calc.mismatches == 0 && calc.due_bytes.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
